/* rtl/core/pmtc_pkg.sv */
// Package for the power-mode transition checker.
// Holds the item, result and rule types, status and state codes.
// No dependencies.
`timescale 1ns / 1ps

package pmtc_pkg;

  localparam int MODE_W   = 3;
  localparam int COST_W   = 24;
  localparam int TOTAL_W  = 48;
  localparam int COUNT_W  = 32;

  localparam logic ACT_ADD     = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef enum logic [2:0] {
    ST_MOVED   = 3'd0,
    ST_SAME    = 3'd1,
    ST_NORULE  = 3'd2,
    ST_ADDED   = 3'd3,
    ST_FULL    = 3'd4,
    ST_BADMODE = 3'd5
  } pmtc_status_t;

  typedef enum logic {
    PMTC_IDLE,
    PMTC_SCAN
  } pmtc_state_t;

  typedef struct packed {
    logic              action;
    logic [MODE_W-1:0] source_mode;
    logic [MODE_W-1:0] dest_mode;
    logic [COST_W-1:0] energy_cost;
    logic [COST_W-1:0] latency;
  } pmtc_item_t;

  typedef struct packed {
    pmtc_status_t       status;
    logic [MODE_W-1:0]  mode;
    logic [TOTAL_W-1:0] energy_total;
    logic [TOTAL_W-1:0] uptime_total;
    logic [COUNT_W-1:0] move_count;
  } pmtc_result_t;

  typedef struct packed {
    logic [MODE_W-1:0] src_mode;
    logic [MODE_W-1:0] to_mode;
    logic [COST_W-1:0] energy;
    logic [COST_W-1:0] lat;
  } pmtc_rule_t;

endpackage

/* rtl/core/pmtc_rule_ram.sv */
// Rule table storage: one write port, one registered read port.
// Depends on pmtc_pkg for the rule type.
`timescale 1ns / 1ps

module pmtc_rule_ram
  import pmtc_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  pmtc_rule_t       wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output pmtc_rule_t       rd_data
);

  pmtc_rule_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/power_mode_transition_checker.sv */
// Power-mode transition checker top level: mode state, totals and rule search.
// Depends on pmtc_pkg and pmtc_rule_ram.
//
//  channel   | signals                      | transfer
//  ----------+------------------------------+------------------------------
//  item in   | start, busy, item            | start high while busy low
//  result    | result_valid, result         | one-cycle strobe, no stall
//  config    | cfg_valid, cfg_ready, cfg_data | cfg_valid and cfg_ready high
//
// An add, a bad mode, a request for the current mode or a request with an
// empty table answers in the cycle after the transfer. A search reads one
// rule a cycle from the rule RAM, compares it in the next cycle, and answers
// at the first match or after the last stored rule. rst is synchronous and
// clears mode, counters and totals; the rule RAM is not cleared. The result
// receiver cannot stall.
`timescale 1ns / 1ps

module power_mode_transition_checker
  import pmtc_pkg::*;
#(
  parameter int MAX_RULES  = 16,
  parameter int MODE_COUNT = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pmtc_item_t        item,
  output logic              result_valid,
  output pmtc_result_t      result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MODE_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam logic [MODE_W-1:0] MODE_MAX = MODE_W'(MODE_COUNT - 1);
  localparam logic [CNT_W-1:0]  RULES_MAX = CNT_W'(MAX_RULES);

  pmtc_state_t        state, state_next;
  logic [MODE_W-1:0]  cur_mode, cur_mode_next;
  logic [TOTAL_W-1:0] energy_sum, energy_sum_next;
  logic [TOTAL_W-1:0] uptime_sum, uptime_sum_next;
  logic [COUNT_W-1:0] moves, moves_next;
  logic [CNT_W-1:0]   rule_count;
  logic [CNT_W-1:0]   rd_cnt;
  logic [CNT_W-1:0]   rd_cnt_inc;
  logic               chk_valid;
  logic               chk_last;
  logic [MODE_W-1:0]  req_target;

  logic               accept;
  logic               cfg_write;
  logic               src_ok;
  logic               dst_ok;
  logic               match;
  logic               scan_go;
  logic               scan_end;
  logic               emit;
  logic               do_move;
  logic               wr_en;
  logic               rd_en;
  pmtc_status_t       status_code;
  pmtc_rule_t         wr_rule;
  pmtc_rule_t         rd_rule;
  logic [TOTAL_W:0]   energy_add;
  logic [TOTAL_W:0]   uptime_add;

  assign busy       = (state != PMTC_IDLE);
  assign cfg_ready  = (state == PMTC_IDLE) && !start;
  assign accept     = start && !busy;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign src_ok     = (item.source_mode <= MODE_MAX);
  assign dst_ok     = (item.dest_mode <= MODE_MAX);
  assign rd_cnt_inc = rd_cnt + CNT_W'(1);
  assign match      = chk_valid && (rd_rule.src_mode == cur_mode)
                      && (rd_rule.to_mode == req_target);

  assign wr_rule.src_mode  = item.source_mode;
  assign wr_rule.to_mode   = item.dest_mode;
  assign wr_rule.energy    = item.energy_cost;
  assign wr_rule.lat       = item.latency;

  pmtc_rule_ram #(
    .DEPTH (MAX_RULES),
    .IDX_W (IDX_W)
  ) u_rule_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (rule_count[IDX_W-1:0]),
    .wr_data (wr_rule),
    .rd_en   (rd_en),
    .rd_addr (rd_cnt[IDX_W-1:0]),
    .rd_data (rd_rule)
  );

  // Control outputs per state.
  always_comb begin
    emit        = 1'b0;
    status_code = ST_NORULE;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    scan_go     = 1'b0;
    scan_end    = 1'b0;
    do_move     = 1'b0;
    case (state)
      PMTC_IDLE: begin
        if (accept) begin
          if (item.action == ACT_ADD) begin
            emit = 1'b1;
            if (!src_ok || !dst_ok) begin
              status_code = ST_BADMODE;
            end else if (rule_count >= RULES_MAX) begin
              status_code = ST_FULL;
            end else begin
              status_code = ST_ADDED;
              wr_en       = 1'b1;
            end
          end else if (!dst_ok) begin
            emit        = 1'b1;
            status_code = ST_BADMODE;
          end else if (item.dest_mode == cur_mode) begin
            emit        = 1'b1;
            status_code = ST_SAME;
          end else if (rule_count == '0) begin
            emit        = 1'b1;
            status_code = ST_NORULE;
          end else begin
            scan_go = 1'b1;
          end
        end
      end
      PMTC_SCAN: begin
        rd_en = (rd_cnt < rule_count);
        if (match) begin
          emit        = 1'b1;
          status_code = ST_MOVED;
          do_move     = 1'b1;
          scan_end    = 1'b1;
        end else if (chk_valid && chk_last) begin
          emit        = 1'b1;
          status_code = ST_NORULE;
          scan_end    = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      PMTC_IDLE: begin
        if (scan_go) begin
          state_next = PMTC_SCAN;
        end
      end
      PMTC_SCAN: begin
        if (scan_end) begin
          state_next = PMTC_IDLE;
        end
      end
      default: begin
        state_next = PMTC_IDLE;
      end
    endcase
  end

  // Saturating totals and mode update.
  always_comb begin
    energy_add      = {1'b0, energy_sum} + (TOTAL_W + 1)'(rd_rule.energy);
    uptime_add      = {1'b0, uptime_sum} + (TOTAL_W + 1)'(rd_rule.lat);
    energy_sum_next = energy_sum;
    uptime_sum_next = uptime_sum;
    moves_next      = moves;
    cur_mode_next   = cur_mode;
    if (do_move) begin
      energy_sum_next = energy_add[TOTAL_W] ? '1 : energy_add[TOTAL_W-1:0];
      uptime_sum_next = uptime_add[TOTAL_W] ? '1 : uptime_add[TOTAL_W-1:0];
      moves_next      = (moves == '1) ? moves : moves + COUNT_W'(1);
      cur_mode_next   = req_target;
    end
    if (cfg_write) begin
      cur_mode_next = (cfg_data > MODE_MAX) ? MODE_MAX : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= PMTC_IDLE;
      cur_mode     <= '0;
      energy_sum   <= '0;
      uptime_sum   <= '0;
      moves        <= '0;
      rule_count   <= '0;
      rd_cnt       <= '0;
      chk_valid    <= 1'b0;
      chk_last     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      cur_mode     <= cur_mode_next;
      energy_sum   <= energy_sum_next;
      uptime_sum   <= uptime_sum_next;
      moves        <= moves_next;
      if (wr_en) begin
        rule_count <= rule_count + CNT_W'(1);
      end
      if (scan_go) begin
        rd_cnt <= '0;
      end else if (rd_en) begin
        rd_cnt <= rd_cnt_inc;
      end
      chk_valid    <= rd_en;
      chk_last     <= (rd_cnt_inc == rule_count);
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_target <= item.dest_mode;
    end
    if (emit) begin
      result.status       <= status_code;
      result.mode         <= cur_mode_next;
      result.energy_total <= energy_sum_next;
      result.uptime_total <= uptime_sum_next;
      result.move_count   <= moves_next;
    end
  end

endmodule

/* tb/tb_top.sv */
// Testbench for power_mode_transition_checker: directed and random items
// checked field by field against a behavioral predictor of the block.
// Depends on pmtc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
  import pmtc_pkg::*;

  localparam int NUM_RULES      = 16;
  localparam int NUM_MODES      = 5;
  localparam int WATCHDOG_LIMIT = 2000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  pmtc_item_t        item;
  logic              result_valid;
  pmtc_result_t      result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [MODE_W-1:0] cfg_data;

  power_mode_transition_checker #(
    .MAX_RULES (NUM_RULES),
    .MODE_COUNT(NUM_MODES)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .result_valid(result_valid),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // Predicted block state
  logic [MODE_W-1:0]  mode_now;
  pmtc_rule_t         rule_mem [NUM_RULES];
  int                 rule_cnt;
  logic [TOTAL_W-1:0] energy_acc;
  logic [TOTAL_W-1:0] uptime_acc;
  logic [COUNT_W-1:0] moves_acc;

  pmtc_result_t pending_answers[$];
  int           errors;
  int           quiet_cycles;
  int           burst_left;
  bit           steady;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic pmtc_result_t predict_answer(pmtc_item_t it);
    pmtc_result_t     res;
    logic [TOTAL_W:0] sum_e;
    logic [TOTAL_W:0] sum_u;
    bit               found;
    res.status = ST_NORULE;
    if (it.action == ACT_ADD) begin
      if (it.source_mode >= NUM_MODES || it.dest_mode >= NUM_MODES) begin
        res.status = ST_BADMODE;
      end else if (rule_cnt >= NUM_RULES) begin
        res.status = ST_FULL;
      end else begin
        rule_mem[rule_cnt] = '{src_mode: it.source_mode, to_mode: it.dest_mode,
                               energy: it.energy_cost, lat: it.latency};
        rule_cnt++;
        res.status = ST_ADDED;
      end
    end else if (it.dest_mode >= NUM_MODES) begin
      res.status = ST_BADMODE;
    end else if (it.dest_mode == mode_now) begin
      res.status = ST_SAME;
    end else begin
      found = 1'b0;
      for (int i = 0; i < rule_cnt; i++) begin
        if (!found && rule_mem[i].src_mode == mode_now &&
            rule_mem[i].to_mode == it.dest_mode) begin
          found = 1'b1;
          sum_e = {1'b0, energy_acc} + (TOTAL_W + 1)'(rule_mem[i].energy);
          sum_u = {1'b0, uptime_acc} + (TOTAL_W + 1)'(rule_mem[i].lat);
          energy_acc = sum_e[TOTAL_W] ? '1 : sum_e[TOTAL_W-1:0];
          uptime_acc = sum_u[TOTAL_W] ? '1 : sum_u[TOTAL_W-1:0];
          if (moves_acc != '1) moves_acc++;
          mode_now = it.dest_mode;
          res.status = ST_MOVED;
        end
      end
    end
    res.mode         = mode_now;
    res.energy_total = energy_acc;
    res.uptime_total = uptime_acc;
    res.move_count   = moves_acc;
    return res;
  endfunction

  function automatic pmtc_item_t make_item(logic act, logic [MODE_W-1:0] src,
                                           logic [MODE_W-1:0] dst,
                                           logic [COST_W-1:0] cost,
                                           logic [COST_W-1:0] lat);
    pmtc_item_t it;
    it.action      = act;
    it.source_mode = src;
    it.dest_mode   = dst;
    it.energy_cost = cost;
    it.latency     = lat;
    return it;
  endfunction

  function automatic logic [COST_W-1:0] pick_amount();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COST_W'($urandom);
    endcase
  endfunction

  function automatic pmtc_item_t build_random_item();
    pmtc_item_t it;
    int         hits[$];
    int         add_pct;
    if ($urandom_range(0, 3) == 0) begin
      it = make_item(1'($urandom), MODE_W'($urandom), MODE_W'($urandom),
                     pick_amount(), pick_amount());
    end else begin
      add_pct = (rule_cnt < NUM_RULES) ? 25 : 5;
      if ($urandom_range(0, 99) < add_pct) begin
        it = make_item(ACT_ADD, MODE_W'($urandom_range(0, NUM_MODES - 1)),
                       MODE_W'($urandom_range(0, NUM_MODES - 1)),
                       pick_amount(), pick_amount());
      end else begin
        for (int i = 0; i < rule_cnt; i++)
          if (rule_mem[i].src_mode == mode_now) hits.push_back(i);
        it = make_item(ACT_REQUEST, MODE_W'($urandom),
                       MODE_W'($urandom_range(0, NUM_MODES - 1)),
                       COST_W'($urandom), COST_W'($urandom));
        if (hits.size() > 0 && $urandom_range(0, 9) < 7)
          it.dest_mode = rule_mem[hits[$urandom_range(0, hits.size() - 1)]].to_mode;
      end
    end
    return it;
  endfunction

  task automatic send_item(pmtc_item_t it);
    int gap;
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left--;
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    pending_answers.push_back(predict_answer(it));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
  endtask

  task automatic write_start_mode(logic [MODE_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    mode_now  = (value >= NUM_MODES) ? MODE_W'(NUM_MODES - 1) : value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_item(make_item(ACT_REQUEST, 3'd0, 3'd0, '0, '0));
    send_item(make_item(ACT_REQUEST, 3'd7, 3'd2, '1, '1));
    send_item(make_item(ACT_REQUEST, 3'd0, 3'd7, '0, '0));
    send_item(make_item(ACT_REQUEST, 3'd0, 3'd5, '0, '0));
    send_item(make_item(ACT_ADD, 3'd5, 3'd1, 24'h10, 24'h10));
    send_item(make_item(ACT_ADD, 3'd1, 3'd6, 24'h10, 24'h10));
  endtask

  task automatic test_rule_search();
    send_item(make_item(ACT_ADD, 3'd0, 3'd1, '1, '0));
    send_item(make_item(ACT_ADD, 3'd0, 3'd1, 24'd1, 24'd1));
    send_item(make_item(ACT_ADD, 3'd1, 3'd4, '0, '1));
    send_item(make_item(ACT_ADD, 3'd4, 3'd0, 24'h123456, 24'hABCDEF));
    send_item(make_item(ACT_REQUEST, 3'd7, 3'd1, '1, '1));
    send_item(make_item(ACT_REQUEST, 3'd0, 3'd1, '0, '0));
    send_item(make_item(ACT_REQUEST, 3'd0, 3'd3, '0, '0));
    send_item(make_item(ACT_REQUEST, 3'd0, 3'd4, '0, '0));
    send_item(make_item(ACT_REQUEST, 3'd0, 3'd0, '0, '0));
    send_item(make_item(ACT_REQUEST, 3'd2, 3'd1, 24'h5A5A5A, 24'hA5A5A5));
  endtask

  task automatic test_start_mode();
    write_start_mode(3'd4);
    send_item(make_item(ACT_REQUEST, 3'd0, 3'd4, '0, '0));
    write_start_mode(3'd7);
    send_item(make_item(ACT_REQUEST, 3'd0, 3'd0, '0, '0));
    write_start_mode(3'd3);
    send_item(make_item(ACT_REQUEST, 3'd0, 3'd3, '0, '0));
    write_start_mode(3'd0);
  endtask

  task automatic test_random();
    logic [MODE_W-1:0] modes[5] = '{3'd7, 3'd0, 3'd4, 3'd5, 3'd2};
    for (int phase = 0; phase < 5; phase++) begin
      steady = (phase == 2);
      for (int n = 0; n < 80; n++) send_item(build_random_item());
      write_start_mode((phase == 4) ? MODE_W'($urandom) : modes[phase]);
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin : answer_check
    pmtc_result_t want;
    if (!rst && result_valid) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result status", result.status, '0);
      end else begin
        want = pending_answers.pop_front();
        if (result.status != want.status)
          report_mismatch("status", result.status, want.status);
        if (result.mode != want.mode)
          report_mismatch("mode", result.mode, want.mode);
        if (result.energy_total != want.energy_total)
          report_mismatch("energy_total", result.energy_total, want.energy_total);
        if (result.uptime_total != want.uptime_total)
          report_mismatch("uptime_total", result.uptime_total, want.uptime_total);
        if (result.move_count != want.move_count)
          report_mismatch("move_count", result.move_count, want.move_count);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    item         = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    errors       = 0;
    quiet_cycles = 0;
    burst_left   = 0;
    steady       = 1'b0;
    mode_now     = '0;
    rule_cnt     = 0;
    energy_acc   = '0;
    uptime_acc   = '0;
    moves_acc    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_rule_search();
    test_start_mode();
    test_random();

    wait_idle();
    repeat (NUM_RULES + 4) @(posedge clk);
    if (pending_answers.size() != 0)
      report_mismatch("missing results", pending_answers.size(), '0);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
